// ===== rtl/alhu_pkg.sv =====
`default_nettype none
package alhu_pkg;

  localparam int LED_COUNT    = 30;
  localparam int DEG_FULL     = 360;
  localparam int SPREAD_W     = 9;
  localparam int SPREAD_RESET = 120;
  localparam int NUM_W        = 13;  // ten times a distance of up to 511 degrees
  localparam int KQ_W         = 4;   // divide-down factor stays within 1..11
  localparam int KDIV_TOP_BIT = 3;
  localparam int CDIV_TOP_BIT = 7;

  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] angle;
  } in_t;

  typedef struct packed {
    logic [4:0] led_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_KDIV,
    ST_CDIV,
    ST_LOAD
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start;      // capture request, rewind to the first LED
    logic       eval;       // register hit test and distance for the current LED
    logic       kdiv_step;  // one quotient bit of the divide-down factor
    logic       cdiv_step;  // one quotient bit of each color channel
    logic       load_out;   // move the finished LED into the output register
    logic       next_led;   // advance to the next LED
    logic [2:0] bit_idx;    // quotient bit under work
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;      // request on the input produces no results
    logic lit;       // current LED falls inside the spot
    logic last_led;  // current LED is the final one on the ring
    logic out_free;  // output register can take a result this cycle
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/alhu_ctrl.sv =====
`default_nettype none
module alhu_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire alhu_pkg::stat_t stat_i,
  output alhu_pkg::cmd_t      cmd_o
);
  import alhu_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.bit_idx = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !stat_i.skip) begin
          cmd_o.start = 1'b1;
          state_d     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (stat_i.lit) begin
          cnt_d   = 3'(KDIV_TOP_BIT);
          state_d = ST_KDIV;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_KDIV: begin
        cmd_o.kdiv_step = 1'b1;
        if (cnt_q == 3'd0) begin
          cnt_d   = 3'(CDIV_TOP_BIT);
          state_d = ST_CDIV;
        end else begin
          cnt_d = cnt_q - 3'd1;
        end
      end
      ST_CDIV: begin
        cmd_o.cdiv_step = 1'b1;
        if (cnt_q == 3'd0) begin
          state_d = ST_LOAD;
        end else begin
          cnt_d = cnt_q - 3'd1;
        end
      end
      ST_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (stat_i.last_led) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.next_led = 1'b1;
            state_d        = ST_EVAL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/alhu_dp.sv =====
`default_nettype none
module alhu_dp #(
  parameter int LedCount = alhu_pkg::LED_COUNT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [alhu_pkg::SPREAD_W-1:0] cfg_wdata_i,
  input  wire alhu_pkg::in_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output alhu_pkg::out_t                     out_data_o,
  input  wire alhu_pkg::cmd_t                cmd_i,
  output alhu_pkg::stat_t                    stat_o
);
  import alhu_pkg::*;

  localparam int LedW = (LedCount > 1) ? $clog2(LedCount) : 1;
  localparam int Step = DEG_FULL / LedCount;

  logic [SPREAD_W-1:0] spread_q;
  logic [23:0]         last_color_q;
  in_t                 item_q;
  logic [LedW-1:0]     led_q;
  logic [8:0]          pos_q;
  logic                lit_q;
  logic [NUM_W-1:0]    rem_q, rem_d;
  logic [KQ_W-1:0]     kq_q, kq_d;
  logic [7:0]          dv_q [3];
  logic [7:0]          dv_d [3];
  logic [3:0]          crem_q [3];
  logic [3:0]          crem_d [3];
  out_t                out_q;
  logic                out_valid_q;

  logic                geo_lit;
  logic signed [11:0]  a_s, t_s, l_s, full_s, diff_abs, dist_s;
  logic [8:0]          led_gap;
  logic [NUM_W-1:0]    num;
  logic [NUM_W-1:0]    tsh;
  logic [KQ_W-1:0]     k_w;
  logic [4:0]          tmp [3];
  logic                ge [3];
  logic [31:0]         led_ext;

  // Configuration, history and the output valid flag, all reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spread_q     <= SPREAD_W'(SPREAD_RESET);
      last_color_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        spread_q <= cfg_wdata_i;
      end
      if (cmd_i.start && !in_data_i.op) begin
        last_color_q <= {in_data_i.red, in_data_i.green, in_data_i.blue};
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.skip = !in_data_i.op &&
                       (({in_data_i.red, in_data_i.green, in_data_i.blue} == last_color_q) ||
                        (in_data_i.angle >= 9'(DEG_FULL)));
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.last_led = (led_q == LedW'(LedCount - 1));
  assign stat_o.lit      = geo_lit && !item_q.op;

  // Hit test of the current LED against the spot, with wrap around zero degrees.
  always_comb begin
    a_s      = $signed({3'b000, item_q.angle});
    t_s      = $signed({3'b000, spread_q});
    l_s      = $signed({3'b000, pos_q});
    full_s   = 12'(DEG_FULL);
    diff_abs = (a_s > l_s) ? (a_s - l_s) : (l_s - a_s);
    geo_lit  = 1'b0;
    dist_s   = '0;
    if (a_s < t_s) begin
      if (l_s >= a_s + full_s - t_s) begin
        geo_lit = 1'b1;
        dist_s  = a_s + full_s - l_s;
      end else if (l_s < a_s + t_s) begin
        geo_lit = 1'b1;
        dist_s  = diff_abs;
      end
    end else if (a_s >= full_s - t_s) begin
      if (l_s <= a_s - full_s + t_s) begin
        geo_lit = 1'b1;
        dist_s  = l_s + full_s - a_s;
      end else if (l_s > a_s - t_s) begin
        geo_lit = 1'b1;
        dist_s  = diff_abs;
      end
    end else if ((l_s >= a_s - t_s) && (l_s <= a_s + t_s)) begin
      geo_lit = 1'b1;
      dist_s  = diff_abs;
    end
    // A lit LED is never farther than the spread, so nine bits hold it.
    led_gap = dist_s[8:0];
    num     = (NUM_W'(led_gap) << 3) + (NUM_W'(led_gap) << 1);
  end

  // Factor k = 1 + 10*dist/spread; quotient stays at or below ten.
  assign tsh = NUM_W'(spread_q) << cmd_i.bit_idx[1:0];
  assign k_w = (spread_q == '0) ? KQ_W'(1) : (kq_q + KQ_W'(1));

  always_comb begin
    rem_d = rem_q;
    kq_d  = kq_q;
    if (cmd_i.eval) begin
      rem_d = num;
      kq_d  = '0;
    end else if (cmd_i.kdiv_step && (rem_q >= tsh)) begin
      rem_d = rem_q - tsh;
      kq_d[cmd_i.bit_idx[1:0]] = 1'b1;
    end
  end

  // Three channel lanes, restoring division by k, quotient shifts into the dividend.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tmp[j]    = {crem_q[j], dv_q[j][7]};
      ge[j]     = (tmp[j] >= {1'b0, k_w});
      dv_d[j]   = dv_q[j];
      crem_d[j] = crem_q[j];
      if (cmd_i.cdiv_step) begin
        crem_d[j] = ge[j] ? 4'(tmp[j] - {1'b0, k_w}) : tmp[j][3:0];
        dv_d[j]   = {dv_q[j][6:0], ge[j]};
      end
    end
    if (cmd_i.eval) begin
      dv_d[0]   = item_q.red;
      dv_d[1]   = item_q.green;
      dv_d[2]   = item_q.blue;
      crem_d[0] = '0;
      crem_d[1] = '0;
      crem_d[2] = '0;
    end
  end

  assign led_ext = 32'(led_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      item_q <= in_data_i;
      led_q  <= '0;
      pos_q  <= '0;
    end else if (cmd_i.next_led) begin
      led_q  <= led_q + LedW'(1);
      pos_q  <= pos_q + 9'(Step);
    end
    if (cmd_i.eval) begin
      lit_q <= stat_o.lit;
    end
    rem_q <= rem_d;
    kq_q  <= kq_d;
    for (int j = 0; j < 3; j++) begin
      dv_q[j]   <= dv_d[j];
      crem_q[j] <= crem_d[j];
    end
    if (cmd_i.load_out) begin
      out_q.led_index <= led_ext[4:0];
      out_q.out_red   <= lit_q ? dv_q[0] : 8'd0;
      out_q.out_green <= lit_q ? dv_q[1] : 8'd0;
      out_q.out_blue  <= lit_q ? dv_q[2] : 8'd0;
      out_q.last      <= stat_o.last_led;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/angular_led_ring_highlight_unit.sv =====
`default_nettype none
// Flow: a show request is taken in the idle state; each LED then passes the eval state and,
//   when lit, the divider before the load state; a dark LED or a blank goes straight to load.
// The walk handles one LED at a time and stalls in the load state while the output is full;
//   the bit-serial divider (4 factor steps, then 8 channel steps) runs only for lit LEDs.
// A request whose results are all computed frees the input while the final result waits.
// Reset: spread returns to 120, last color to black, output register empties.
module angular_led_ring_highlight_unit #(
  parameter int LedCount = alhu_pkg::LED_COUNT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [alhu_pkg::SPREAD_W-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire alhu_pkg::in_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output alhu_pkg::out_t                     out_data_o
);
  import alhu_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: take a request, walk the ring one LED at a time,
  // run the divider only for LEDs that fall inside the spot.
  alhu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: spread register, last color, hit test, shared divider, output register.
  alhu_dp #(
    .LedCount (LedCount)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  // Datapath commands never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start, cmd.eval, cmd.kdiv_step, cmd.cdiv_step, cmd.load_out}))
    else $error("overlapping datapath commands");

  // Never overwrite a result that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> stat.out_free)
    else $error("output register overwritten");

  // A started request blocks the input until its ring walk ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> !in_ready_o)
    else $error("input ready while a request is in work");

  // The ring walk only advances together with moving a result out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.next_led |-> cmd.load_out)
    else $error("LED advanced without a result");

endmodule
`default_nettype wire
